@@ src/mbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Multibit trie route lookup package
// Shared types, field layout, trie geometry and helper functions.
// ----------------------------------------------------------------------------
package mbt_pkg;

  // Trie geometry: a 12-bit root level and four 5-bit child levels.
  localparam int RootBits      = 12;
  localparam int ChildBits     = 5;
  localparam int RootBuckets   = 4096;
  localparam int ChildBuckets  = 32;
  localparam int RootKeySpan   = 2 * RootBuckets;
  localparam int ChildKeySpan  = 2 * ChildBuckets;
  localparam int LastLevel     = 4;

  localparam int DefRouteSlots = 1024;
  localparam int DefNodePool   = 256;

  // Stream word layout.
  localparam int InDataW  = 88;
  localparam int OutDataW = 56;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_WK_RD,
    S_WK_EV,
    S_PK_RD,
    S_PK_EV,
    S_PP_RD,
    S_PP_EV,
    S_PREV,
    S_RT_RD,
    S_RT_EV,
    S_ACT,
    S_FL_RD,
    S_FL_EV,
    S_INST,
    S_ALLOC,
    S_FILL,
    S_FREEOLD,
    S_DONE
  } state_e;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [2:0]  target;
    logic [12:0] i1;
    logic [31:0] gw;
    logic [15:0] port;
    logic        repl;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        hit;
    logic [31:0] gw;
    logic [15:0] port;
  } res_t;

  function automatic logic [11:0] lvl_index(logic [2:0] lv, logic [31:0] addr);
    logic [11:0] r;
    case (lv)
      3'd0:    r = addr[31:20];
      3'd1:    r = {7'd0, addr[19:15]};
      3'd2:    r = {7'd0, addr[14:10]};
      3'd3:    r = {7'd0, addr[9:5]};
      default: r = {7'd0, addr[4:0]};
    endcase
    return r;
  endfunction

  // Heap slot of the leaf for an index at a level.
  function automatic logic [12:0] leaf_slot(logic [2:0] lv, logic [11:0] idx);
    logic [12:0] r;
    if (lv == 3'd0) begin
      r = {1'b1, idx};
    end else begin
      r = {7'd0, 1'b1, idx[4:0]};
    end
    return r;
  endfunction

  // One past the last heap slot of a node at a level.
  function automatic logic [13:0] heap_top(logic [2:0] lv);
    logic [13:0] r;
    if (lv == 3'd0) begin
      r = 14'(RootKeySpan);
    end else begin
      r = 14'(ChildKeySpan);
    end
    return r;
  endfunction

endpackage

@@ src/multibit_trie_route_lookup.sv @@
// ----------------------------------------------------------------------------
// Multibit trie route lookup
// IPv4 longest-prefix-match table with lookup, add and remove commands.
// A lookup reads the key and link words of each trie level it walks, then the
// route store when a route is found, and passes the queue, dispatch and
// output register. Add and remove walk the trie links toward the prefix's level;
// a successful add or remove of a nonzero-length prefix then scans every heap slot
// of its subtree (up to 4095 slots for a one-bit prefix); one command is worked at a time.
// After reset a clearing pass over 8192 + 64 * NODE_POOL key words zeroes the
// trie memories; commands queue but are not started until it ends.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup #(
  parameter int ROUTE_SLOTS = mbt_pkg::DefRouteSlots,
  parameter int NODE_POOL   = mbt_pkg::DefNodePool
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // address[31:0], prefix_len[37:32], gateway[69:38], port[85:70], replace[86]
  input  logic [mbt_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit[0], hop_gateway[32:1], hop_port[48:33]
  output logic [mbt_pkg::OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]                   m_axis_tuser
);
  import mbt_pkg::*;

  logic req_valid, req_ready, eng_done, out_ready;
  req_t req;
  res_t eng_res;
  res_t out_q;
  logic out_valid_q;

  mbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .data_i      (s_axis_tdata),
    .user_i      (s_axis_tuser),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  mbt_engine #(
    .ROUTE_SLOTS (ROUTE_SLOTS),
    .NODE_POOL   (NODE_POOL)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .done_o      (eng_done),
    .res_o       (eng_res),
    .out_ready_i (out_ready)
  );

  // The output register frees the engine as soon as a word is handed over.
  assign out_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done && out_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done && out_ready) begin
      out_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.port, out_q.gw, out_q.hit};

endmodule

@@ src/mbt_front.sv @@
// ----------------------------------------------------------------------------
// Multibit trie front end
// Accepts command words, masks the prefix, finds its level and heap slot,
// and queues the classified request for the engine.
// ----------------------------------------------------------------------------
module mbt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  // address[31:0], prefix_len[37:32], gateway[69:38], port[85:70], replace[86]
  input  logic [mbt_pkg::InDataW-1:0] data_i,
  // cmd[1:0]
  input  logic [1:0]                  user_i,
  output logic                        req_valid_o,
  output mbt_pkg::req_t               req_o,
  input  logic                        req_ready_i
);
  import mbt_pkg::*;

  logic [5:0]  plen_c;
  logic [31:0] mask;
  logic [31:0] addr_m;
  logic [2:0]  tgt;
  logic [3:0]  kk;
  logic [11:0] idx;
  logic [12:0] i1;
  cmd_e        cmd;
  req_t        req_c;

  req_t        q_mem [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  always_comb begin
    cmd    = cmd_e'(user_i);
    plen_c = (data_i[37:32] > 6'd32) ? 6'd32 : data_i[37:32];
    mask   = ~(32'hFFFF_FFFF >> plen_c);
    addr_m = data_i[31:0] & mask;
    if (plen_c <= 6'd12) begin
      tgt = 3'd0;
      kk  = plen_c[3:0];
    end else if (plen_c <= 6'd17) begin
      tgt = 3'd1;
      kk  = 4'(plen_c - 6'd12);
    end else if (plen_c <= 6'd22) begin
      tgt = 3'd2;
      kk  = 4'(plen_c - 6'd17);
    end else if (plen_c <= 6'd27) begin
      tgt = 3'd3;
      kk  = 4'(plen_c - 6'd22);
    end else begin
      tgt = 3'd4;
      kk  = 4'(plen_c - 6'd27);
    end
    idx = lvl_index(tgt, addr_m);
    if (tgt == 3'd0) begin
      i1 = leaf_slot(tgt, idx) >> (4'd12 - kk);
    end else begin
      i1 = leaf_slot(tgt, idx) >> (4'd5 - kk);
    end
    req_c.cmd    = cmd;
    // A lookup walks the full address; updates use the masked prefix.
    req_c.addr   = (cmd == CMD_LOOKUP) ? data_i[31:0] : addr_m;
    req_c.plen   = plen_c;
    req_c.target = tgt;
    req_c.i1     = i1;
    req_c.gw     = data_i[69:38];
    req_c.port   = data_i[85:70];
    req_c.repl   = data_i[86];
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = q_mem[rp_q];
  assign push        = valid_i && ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= req_c;
    end
  end

endmodule

@@ src/mbt_engine.sv @@
// ----------------------------------------------------------------------------
// Multibit trie engine
// Sequencer that walks the trie memories, maintains the route store and its
// free list, allocates nodes and rewrites heap key slots.
// ----------------------------------------------------------------------------
module mbt_engine #(
  parameter int ROUTE_SLOTS = mbt_pkg::DefRouteSlots,
  parameter int NODE_POOL   = mbt_pkg::DefNodePool
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  mbt_pkg::req_t req_i,
  output logic          req_ready_o,
  output logic          done_o,
  output mbt_pkg::res_t res_o,
  input  logic          out_ready_i
);
  import mbt_pkg::*;

  localparam int KW  = $clog2(ROUTE_SLOTS + 1);
  localparam int SW  = $clog2(ROUTE_SLOTS);
  localparam int LW  = $clog2(NODE_POOL + 1);
  localparam int NW  = $clog2(NODE_POOL);
  localparam int KD  = RootKeySpan + NODE_POOL * ChildKeySpan;
  localparam int KAW = $clog2(KD);
  localparam int LD  = RootBuckets + NODE_POOL * ChildBuckets;
  localparam int LAW = $clog2(LD);

  function automatic logic [KAW-1:0] kaddr(logic [2:0] lv, logic [NW-1:0] nd,
                                            logic [12:0] i);
    logic [KAW-1:0] r;
    if (lv == 3'd0) begin
      r = KAW'(i);
    end else begin
      r = KAW'(RootKeySpan) + KAW'({nd, i[5:0]});
    end
    return r;
  endfunction

  function automatic logic [LAW-1:0] laddr(logic [2:0] lv, logic [NW-1:0] nd,
                                            logic [11:0] idx);
    logic [LAW-1:0] r;
    if (lv == 3'd0) begin
      r = LAW'(idx);
    end else begin
      r = LAW'(RootBuckets) + LAW'({nd, idx[4:0]});
    end
    return r;
  endfunction

  // Memories
  logic [KW-1:0] kmem [KD];
  logic [LW-1:0] lmem [LD];
  logic [37:0]   rpmem [ROUTE_SLOTS];
  logic [47:0]   rhmem [ROUTE_SLOTS];
  logic [KW-1:0] flmem [ROUTE_SLOTS];

  logic           kwe, lwe, rwe, fwe;
  logic [KAW-1:0] kwa, kra;
  logic [KW-1:0]  kwd, k_rd_q;
  logic [LAW-1:0] lwa, lra;
  logic [LW-1:0]  lwd, l_rd_q;
  logic [SW-1:0]  rwa, rra, fwa, fra;
  logic [KW-1:0]  fwd, f_rd_q;
  logic [37:0]    rp_rd_q;
  logic [47:0]    rh_rd_q;

  always_ff @(posedge clk_i) begin
    if (kwe) begin
      kmem[kwa] <= kwd;
    end
    k_rd_q <= kmem[kra];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      lmem[lwa] <= lwd;
    end
    l_rd_q <= lmem[lra];
  end

  always_ff @(posedge clk_i) begin
    if (rwe) begin
      rpmem[rwa] <= {req_q.addr, req_q.plen};
      rhmem[rwa] <= {req_q.gw, req_q.port};
    end
    rp_rd_q <= rpmem[rra];
    rh_rd_q <= rhmem[rra];
  end

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      flmem[fwa] <= fwd;
    end
    f_rd_q <= flmem[fra];
  end

  // Control state
  state_e         state_q, state_d;
  logic [KAW-1:0] clr_q, clr_d;
  logic [KW-1:0]  free_head_q, free_head_d;
  logic [KW-1:0]  routes_used_q, routes_used_d;
  logic [LW-1:0]  nodes_used_q, nodes_used_d;
  logic [KW-1:0]  def_key_q, def_key_d;
  logic           pend_q, pend_d, fdone_q, fdone_d;

  // Working registers
  req_t           req_q, req_d;
  logic [2:0]     lv_q, lv_d, reached_q, reached_d;
  logic [NW-1:0]  node_q, node_d;
  logic [KW-1:0]  key_q, key_d, rk_q, rk_d, par_q, par_d, from_q, from_d, to_q, to_d;
  logic [47:0]    hop_q, hop_d;
  logic           pmatch_q, pmatch_d;
  logic [SW-1:0]  slot_q, slot_d;
  logic [12:0]    x_q, x_d, xp_q, xp_d;
  logic [13:0]    lo_q, lo_d, w_q, w_d;
  res_t           res_q, res_d;

  logic [11:0]    lv_idx;
  logic [KW-1:0]  key_m1;
  logic [SW-1:0]  key_slot;
  logic [KW-1:0]  newkey;
  logic [LW:0]    nodes_need;

  assign lv_idx     = lvl_index(lv_q, req_q.addr);
  assign key_m1     = key_q - KW'(1);
  assign key_slot   = key_m1[SW-1:0];
  assign newkey     = KW'(slot_q) + KW'(1);
  assign nodes_need = {1'b0, nodes_used_q} + (LW+1)'(req_q.target - reached_q);
  assign res_o      = res_q;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    free_head_d   = free_head_q;
    routes_used_d = routes_used_q;
    nodes_used_d  = nodes_used_q;
    def_key_d     = def_key_q;
    pend_d        = pend_q;
    fdone_d       = fdone_q;
    req_d         = req_q;
    lv_d          = lv_q;
    reached_d     = reached_q;
    node_d        = node_q;
    key_d         = key_q;
    rk_d          = rk_q;
    par_d         = par_q;
    from_d        = from_q;
    to_d          = to_q;
    hop_d         = hop_q;
    pmatch_d      = pmatch_q;
    slot_d        = slot_q;
    x_d           = x_q;
    xp_d          = xp_q;
    lo_d          = lo_q;
    w_d           = w_q;
    res_d         = res_q;
    kwe = 1'b0; kwa = '0; kwd = '0; kra = '0;
    lwe = 1'b0; lwa = '0; lwd = '0; lra = '0;
    rwe = 1'b0; rwa = '0; rra = '0;
    fwe = 1'b0; fwa = '0; fwd = '0; fra = '0;
    req_ready_o = 1'b0;
    done_o      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        kwe = 1'b1;
        kwa = clr_q;
        if (clr_q < KAW'(LD)) begin
          lwe = 1'b1;
          lwa = clr_q[LAW-1:0];
        end
        clr_d = clr_q + KAW'(1);
        if (clr_q == KAW'(KD - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d     = req_i;
          lv_d      = 3'd0;
          node_d    = '0;
          rk_d      = '0;
          par_d     = '0;
          reached_d = 3'd0;
          res_d     = '{status: ST_NOT_FOUND, hit: 1'b0, gw: '0, port: '0};
          case (req_i.cmd)
            CMD_LOOKUP: begin
              key_d   = def_key_q;
              state_d = S_LK_RD;
            end
            CMD_ADD, CMD_REMOVE: begin
              if (req_i.plen == 6'd0) begin
                key_d   = def_key_q;
                state_d = S_PREV;
              end else begin
                key_d   = '0;
                state_d = (req_i.target == 3'd0) ? S_PK_RD : S_WK_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_LK_RD: begin
        kra     = kaddr(lv_q, node_q, leaf_slot(lv_q, lv_idx));
        lra     = laddr(lv_q, node_q, lv_idx);
        state_d = S_LK_EV;
      end

      S_LK_EV: begin
        if (k_rd_q != '0) begin
          key_d = k_rd_q;
        end
        if (l_rd_q == '0 || lv_q == 3'(LastLevel)) begin
          state_d = S_PREV;
        end else begin
          node_d  = NW'(l_rd_q - LW'(1));
          lv_d    = lv_q + 3'd1;
          state_d = S_LK_RD;
        end
      end

      S_WK_RD: begin
        lra     = laddr(lv_q, node_q, lv_idx);
        state_d = S_WK_EV;
      end

      S_WK_EV: begin
        if (l_rd_q == '0) begin
          reached_d = lv_q;
          state_d   = S_PREV;
        end else begin
          node_d = NW'(l_rd_q - LW'(1));
          lv_d   = lv_q + 3'd1;
          if (lv_q + 3'd1 == req_q.target) begin
            reached_d = req_q.target;
            state_d   = S_PK_RD;
          end else begin
            state_d = S_WK_RD;
          end
        end
      end

      S_PK_RD: begin
        kra     = kaddr(req_q.target, node_q, req_q.i1);
        state_d = S_PK_EV;
      end

      S_PK_EV: begin
        rk_d  = k_rd_q;
        key_d = k_rd_q;
        if (k_rd_q != '0 && req_q.i1 > 13'd3) begin
          state_d = S_PP_RD;
        end else begin
          state_d = S_PREV;
        end
      end

      S_PP_RD: begin
        kra     = kaddr(req_q.target, node_q, req_q.i1 >> 1);
        state_d = S_PP_EV;
      end

      S_PP_EV: begin
        par_d = k_rd_q;
        // A key inherited from the parent slot is not a route of this prefix.
        if (k_rd_q == key_q) begin
          key_d = '0;
        end
        state_d = S_PREV;
      end

      S_PREV: begin
        if (key_q != '0) begin
          state_d = S_RT_RD;
        end else if (req_q.cmd == CMD_LOOKUP) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ACT;
        end
      end

      S_RT_RD: begin
        rra     = key_slot;
        state_d = S_RT_EV;
      end

      S_RT_EV: begin
        hop_d    = rh_rd_q;
        pmatch_d = (rp_rd_q == {req_q.addr, req_q.plen}) &&
                   (rh_rd_q == {req_q.gw, req_q.port});
        if (req_q.cmd == CMD_LOOKUP) begin
          res_d   = '{status: ST_OK, hit: 1'b1, gw: rh_rd_q[47:16], port: rh_rd_q[15:0]};
          state_d = S_DONE;
        end else begin
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        state_d = S_DONE;
        if (req_q.cmd == CMD_REMOVE) begin
          if (key_q != '0) begin
            res_d = '{status: ST_NOT_FOUND, hit: 1'b1, gw: hop_q[47:16], port: hop_q[15:0]};
            if (pmatch_q) begin
              res_d.status = ST_OK;
              fwe          = 1'b1;
              fwa          = key_slot;
              fwd          = free_head_q;
              free_head_d  = KW'(key_slot);
              if (req_q.plen == 6'd0) begin
                def_key_d = '0;
              end else begin
                from_d  = rk_q;
                to_d    = (req_q.i1 > 13'd3) ? par_q : '0;
                x_d     = req_q.i1;
                lo_d    = 14'(req_q.i1);
                w_d     = 14'd1;
                pend_d  = 1'b0;
                fdone_d = 1'b0;
                state_d = S_FILL;
              end
            end
          end
        end else if (req_q.cmd == CMD_ADD) begin
          if (key_q != '0 && !req_q.repl) begin
            res_d = '{status: ST_EXISTS, hit: 1'b1, gw: hop_q[47:16], port: hop_q[15:0]};
          end else if ((free_head_q >= KW'(ROUTE_SLOTS) &&
                        routes_used_q >= KW'(ROUTE_SLOTS)) ||
                       (req_q.plen != 6'd0 && nodes_need > (LW+1)'(NODE_POOL))) begin
            res_d.status = ST_FULL;
          end else if (free_head_q < KW'(ROUTE_SLOTS)) begin
            state_d = S_FL_RD;
          end else begin
            slot_d        = routes_used_q[SW-1:0];
            routes_used_d = routes_used_q + KW'(1);
            state_d       = S_INST;
          end
        end
      end

      S_FL_RD: begin
        fra     = free_head_q[SW-1:0];
        state_d = S_FL_EV;
      end

      S_FL_EV: begin
        slot_d      = free_head_q[SW-1:0];
        free_head_d = (f_rd_q > KW'(ROUTE_SLOTS)) ? KW'(ROUTE_SLOTS) : f_rd_q;
        state_d     = S_INST;
      end

      S_INST: begin
        rwe = 1'b1;
        rwa = slot_q;
        res_d.status = ST_OK;
        if (key_q != '0) begin
          res_d.hit  = 1'b1;
          res_d.gw   = hop_q[47:16];
          res_d.port = hop_q[15:0];
        end
        from_d  = rk_q;
        to_d    = newkey;
        x_d     = req_q.i1;
        lo_d    = 14'(req_q.i1);
        w_d     = 14'd1;
        pend_d  = 1'b0;
        fdone_d = 1'b0;
        if (req_q.plen == 6'd0) begin
          def_key_d = newkey;
          state_d   = (key_q != '0) ? S_FREEOLD : S_DONE;
        end else if (reached_q < req_q.target) begin
          state_d = S_ALLOC;
        end else begin
          state_d = S_FILL;
        end
      end

      S_ALLOC: begin
        // New nodes come straight from the pool, so their links are still zero.
        lwe          = 1'b1;
        lwa          = laddr(lv_q, node_q, lv_idx);
        lwd          = nodes_used_q + LW'(1);
        node_d       = nodes_used_q[NW-1:0];
        nodes_used_d = nodes_used_q + LW'(1);
        lv_d         = lv_q + 3'd1;
        if (lv_q + 3'd1 == req_q.target) begin
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        // Reads run one slot ahead of the compare-and-write of the previous one.
        if (!fdone_q) begin
          kra    = kaddr(req_q.target, node_q, x_q);
          pend_d = 1'b1;
          xp_d   = x_q;
          if (14'(x_q) == lo_q + w_q - 14'd1) begin
            lo_d = lo_q << 1;
            w_d  = w_q << 1;
            x_d  = 13'(lo_q << 1);
            if ((lo_q << 1) >= heap_top(req_q.target)) begin
              fdone_d = 1'b1;
            end
          end else begin
            x_d = x_q + 13'd1;
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && k_rd_q == from_q) begin
          kwe = 1'b1;
          kwa = kaddr(req_q.target, node_q, xp_q);
          kwd = to_q;
        end
        if (fdone_q && !pend_q) begin
          state_d = (req_q.cmd == CMD_ADD && key_q != '0) ? S_FREEOLD : S_DONE;
        end
      end

      S_FREEOLD: begin
        fwe         = 1'b1;
        fwa         = key_slot;
        fwd         = free_head_q;
        free_head_d = KW'(key_slot);
        state_d     = S_DONE;
      end

      S_DONE: begin
        done_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      free_head_q   <= KW'(ROUTE_SLOTS);
      routes_used_q <= '0;
      nodes_used_q  <= '0;
      def_key_q     <= '0;
      pend_q        <= 1'b0;
      fdone_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      free_head_q   <= free_head_d;
      routes_used_q <= routes_used_d;
      nodes_used_q  <= nodes_used_d;
      def_key_q     <= def_key_d;
      pend_q        <= pend_d;
      fdone_q       <= fdone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    lv_q      <= lv_d;
    reached_q <= reached_d;
    node_q    <= node_d;
    key_q     <= key_d;
    rk_q      <= rk_d;
    par_q     <= par_d;
    from_q    <= from_d;
    to_q      <= to_d;
    hop_q     <= hop_d;
    pmatch_q  <= pmatch_d;
    slot_q    <= slot_d;
    x_q       <= x_d;
    xp_q      <= xp_d;
    lo_q      <= lo_d;
    w_q       <= w_d;
    res_q     <= res_d;
  end

`ifndef SYNTHESIS
  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= LW'(NODE_POOL))
    else $error("node pool count past its size");

  a_routes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    routes_used_q <= KW'(ROUTE_SLOTS))
    else $error("route store count past its size");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= KW'(ROUTE_SLOTS))
    else $error("free list head out of range");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |=> (nodes_used_q == $past(nodes_used_q) + LW'(1)))
    else $error("node allocation did not advance the pool");
`endif

endmodule

@@ tb/route_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table checker
// Watches both stream channels, predicts each result word from its own copy
// of the trie and route store, and compares the results field by field.
// ----------------------------------------------------------------------------
module route_table_checker (
  input  logic                         clk_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [mbt_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [1:0]                   s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [mbt_pkg::OutDataW-1:0] m_tdata_i,
  input  logic [1:0]                   m_tuser_i,
  output int                           errors_o,
  output int                           pending_o
);
  import mbt_pkg::*;

  localparam int Slots = DefRouteSlots;
  localparam int Pool  = DefNodePool;

  int unsigned root_keys [RootKeySpan-2];
  int unsigned root_lnk  [RootBuckets];
  int unsigned node_keys [Pool][ChildKeySpan-2];
  int unsigned node_lnk  [Pool][ChildBuckets];
  int unsigned nodes_used, def_key, free_head, routes_used;
  logic [37:0] route_pfx [Slots];
  logic [47:0] route_hop [Slots];
  int unsigned free_link [Slots];

  res_t expected_hops [$];
  int   errors;
  int   pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic int unsigned bits_of(int unsigned lv);
    return lv == 0 ? RootBits : ChildBits;
  endfunction

  function automatic int unsigned slice(int unsigned lv, logic [31:0] a);
    return lv == 0 ? int'(a >> 20) : int'((a >> (20 - 5 * lv)) & 32'd31);
  endfunction

  function automatic int unsigned get_key(int unsigned lv, int unsigned nd, int unsigned i);
    return lv == 0 ? root_keys[i - 2] : node_keys[nd][i - 2];
  endfunction

  function automatic void set_key(int unsigned lv, int unsigned nd, int unsigned i,
                                  int unsigned v);
    if (lv == 0) root_keys[i - 2] = v;
    else node_keys[nd][i - 2] = v;
  endfunction

  function automatic int unsigned get_link(int unsigned lv, int unsigned nd, int unsigned x);
    return lv == 0 ? root_lnk[x] : node_lnk[nd][x];
  endfunction

  function automatic void set_link(int unsigned lv, int unsigned nd, int unsigned x,
                                   int unsigned v);
    if (lv == 0) root_lnk[x] = v;
    else node_lnk[nd][x] = v;
  endfunction

  // Replaces one key by another over the whole subtree below heap slot i.
  function automatic void push_down(int unsigned lv, int unsigned nd, int unsigned i,
                                    int unsigned from, int unsigned to);
    int unsigned top, w;
    top = 2 << bits_of(lv);
    w = 1;
    while (i < top) begin
      for (int unsigned x = i; x < i + w; x++) begin
        if (get_key(lv, nd, x) == from) set_key(lv, nd, x, to);
      end
      i = i * 2;
      w = w * 2;
    end
  endfunction

  function automatic void report_hop(int unsigned key, ref res_t r);
    r.hit  = 1'b1;
    r.gw   = route_hop[key - 1][47:16];
    r.port = route_hop[key - 1][15:0];
  endfunction

  function automatic res_t route_op(logic [1:0] cmd, logic [31:0] addr_in,
                                    logic [5:0] plen_in, logic [31:0] gw,
                                    logic [15:0] port, logic repl);
    res_t r;
    int unsigned plen, target, k, bits, i1, nd, reached, prev, slot, cur, l, rk, nk;
    logic [31:0] mask, addr;
    r = '{status: ST_NOT_FOUND, hit: 1'b0, gw: '0, port: '0};
    plen = plen_in > 32 ? 32 : plen_in;
    mask = plen == 0 ? 32'd0 : (32'hFFFF_FFFF << (32 - plen));
    addr = addr_in & mask;
    nd = 0;
    target = 0;
    i1 = 0;
    if (cmd == CMD_LOOKUP) begin
      cur = def_key;
      for (int unsigned lv = 0; lv < 5; lv++) begin
        rk = get_key(lv, nd, (1 << bits_of(lv)) + slice(lv, addr_in));
        if (rk != 0) cur = rk;
        l = get_link(lv, nd, slice(lv, addr_in));
        if (l == 0) break;
        nd = l - 1;
      end
      if (cur != 0) begin
        report_hop(cur, r);
        r.status = ST_OK;
      end
      return r;
    end
    if (cmd != CMD_ADD && cmd != CMD_REMOVE) return r;

    if (plen == 0) begin
      prev = def_key;
      reached = 0;
    end else begin
      target = plen <= 12 ? 0 : (plen - 13) / 5 + 1;
      k = target == 0 ? plen : plen - 12 - 5 * (target - 1);
      bits = bits_of(target);
      i1 = ((1 << bits) + slice(target, addr)) >> (bits - k);
      reached = 0;
      while (reached < target) begin
        l = get_link(reached, nd, slice(reached, addr));
        if (l == 0) break;
        nd = l - 1;
        reached++;
      end
      prev = 0;
      if (reached == target) begin
        prev = get_key(target, nd, i1);
        // A key inherited from the parent slot belongs to a shorter prefix.
        if (prev != 0 && i1 > 3 && get_key(target, nd, i1 / 2) == prev) prev = 0;
      end
    end

    if (cmd == CMD_REMOVE) begin
      if (prev == 0) return r;
      report_hop(prev, r);
      if (route_pfx[prev - 1] != {addr, plen[5:0]} || route_hop[prev - 1] != {gw, port})
        return r;
      free_link[prev - 1] = free_head;
      free_head = prev - 1;
      if (plen == 0) begin
        def_key = 0;
      end else begin
        rk = get_key(target, nd, i1);
        nk = i1 > 3 ? get_key(target, nd, i1 / 2) : 0;
        push_down(target, nd, i1, rk, nk);
      end
      r.status = ST_OK;
      return r;
    end

    if (prev != 0 && !repl) begin
      report_hop(prev, r);
      r.status = ST_EXISTS;
      return r;
    end
    if (free_head >= Slots && routes_used >= Slots) begin
      r.status = ST_FULL;
      return r;
    end
    if (plen != 0 && nodes_used + (target - reached) > Pool) begin
      r.status = ST_FULL;
      return r;
    end
    if (free_head < Slots) begin
      slot = free_head;
      free_head = free_link[slot] > Slots ? Slots : free_link[slot];
    end else begin
      slot = routes_used++;
    end
    route_pfx[slot] = {addr, plen[5:0]};
    route_hop[slot] = {gw, port};
    if (plen == 0) begin
      def_key = slot + 1;
    end else begin
      nd = 0;
      for (int unsigned lv = 0; lv < target; lv++) begin
        l = get_link(lv, nd, slice(lv, addr));
        if (l == 0) begin
          nodes_used++;
          l = nodes_used;
          set_link(lv, nd, slice(lv, addr), l);
        end
        nd = l - 1;
      end
      push_down(target, nd, i1, get_key(target, nd, i1), slot + 1);
    end
    if (prev != 0) begin
      report_hop(prev, r);
      free_link[prev - 1] = free_head;
      free_head = prev - 1;
    end
    r.status = ST_OK;
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    foreach (root_keys[i]) root_keys[i] = 0;
    foreach (root_lnk[i]) root_lnk[i] = 0;
    foreach (node_keys[i, j]) node_keys[i][j] = 0;
    foreach (node_lnk[i, j]) node_lnk[i][j] = 0;
    foreach (route_pfx[i]) begin
      route_pfx[i] = '0;
      route_hop[i] = '0;
      free_link[i] = 0;
    end
    nodes_used  = 0;
    def_key     = 0;
    free_head   = Slots;
    routes_used = 0;
  end

  always @(posedge clk_i) begin
    res_t want;
    if (s_tvalid_i && s_tready_i) begin
      expected_hops = {expected_hops,
                       route_op(s_tuser_i, s_tdata_i[31:0], s_tdata_i[37:32],
                                s_tdata_i[69:38], s_tdata_i[85:70], s_tdata_i[86])};
    end
    if (m_tvalid_i && m_tready_i) begin
      if (expected_hops.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
      end else begin
        want = expected_hops.pop_front();
        if (m_tuser_i != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser_i);
          errors++;
        end
        if (m_tdata_i[0] != want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, m_tdata_i[0]);
          errors++;
        end
        if (m_tdata_i[32:1] != want.gw) begin
          $error("hop_gateway: expected %h, actual %h", want.gw, m_tdata_i[32:1]);
          errors++;
        end
        if (m_tdata_i[48:33] != want.port) begin
          $error("hop_port: expected %h, actual %h", want.port, m_tdata_i[48:33]);
          errors++;
        end
      end
    end
    pending = expected_hops.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route lookup testbench
// Drives lookup, add, remove and unused command words with random gaps and output stalls;
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import mbt_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [31:0] gw;
    logic [15:0] port;
  } route_t;

  logic                clk, rst_n;
  logic                s_tvalid, s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid, m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;
  int                  errors, pending;
  route_t              installed [$];

  multibit_trie_route_lookup u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
  );

  route_table_checker u_checker (
    .clk_i(clk),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [1:0] cmd, logic [31:0] addr, logic [5:0] plen,
                           logic [31:0] gw, logic [15:0] port, logic repl);
    int unsigned gap;
    route_t      ent;
    gap = gap_len();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {1'b0, repl, port, gw, plen, addr};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cmd == CMD_ADD && plen <= 32) begin
      ent = '{addr: addr, plen: plen, gw: gw, port: port};
      installed = {installed, ent};
    end
  endtask

  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 6'd0;
    if (r < 7) return 6'($urandom_range(1, 12));
    if (r < 10) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(13, 32));
  endfunction

  // Output stalls: mostly ready, short stalls, now and then a long one.
  initial begin
    int unsigned r;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready = 1'b1;
      end else if (r < 97) begin
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  initial begin
    #500ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    route_t      rt;
    logic [31:0] a;
    int unsigned r;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_LOOKUP;
    rst_n    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, default route, field extremes, every command.
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CMD_REMOVE, 32'h0A00_0000, 6'd8, 32'd1, 16'd1, 1'b0);
    send_word(CMD_ADD, 32'h1234_5678, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_word(CMD_LOOKUP, 32'h0000_0000, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0101_0101, 16'h0001, 1'b0);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 32'h0202_0202, 16'h0002, 1'b0);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 32'h0303_0303, 16'h0003, 1'b1);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 6'd1, 32'h0404_0404, 16'h0004, 1'b0);
    send_word(CMD_ADD, 32'hC0A8_0000, 6'd12, 32'h0505_0505, 16'h0005, 1'b0);
    send_word(CMD_ADD, 32'hC0A8_7FFF, 6'd13, 32'h0606_0606, 16'h0006, 1'b0);
    send_word(CMD_ADD, 32'hC0A8_7FFF, 6'd17, 32'h0707_0707, 16'h0007, 1'b0);
    send_word(CMD_LOOKUP, 32'hC0A8_7FFF, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CMD_LOOKUP, 32'hC0A8_0001, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CMD_REMOVE, 32'hC0A8_7FFF, 6'd17, 32'h0707_0707, 16'h0008, 1'b0);
    send_word(CMD_REMOVE, 32'hC0A8_7FFF, 6'd17, 32'h0707_0707, 16'h0007, 1'b0);
    send_word(CMD_REMOVE, 32'h0102_0304, 6'd30, 32'd0, 16'd0, 1'b0);
    send_word(CMD_REMOVE, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_word(CMD_LOOKUP, 32'h0000_0000, 6'd0, 32'd0, 16'd0, 1'b0);
    send_word(CmdUnused, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0, 1'b0);

    // Random: mostly adds, lookups and removes of installed routes.
    repeat (630) begin
      r = $urandom_range(0, 99);
      if (installed.size() != 0) rt = installed[$urandom_range(0, installed.size() - 1)];
      else rt = '{addr: $urandom, plen: 6'd24, gw: $urandom, port: 16'($urandom)};
      a = $urandom;
      if (r < 35) begin
        // Lookup near an installed prefix or anywhere.
        if ($urandom_range(0, 3) != 0) a = (rt.addr & ~(32'hFFFF_FFFF >> 12)) | (a >> 12);
        if ($urandom_range(0, 3) == 0) a = rt.addr;
        send_word(CMD_LOOKUP, a, 6'($urandom), $urandom, 16'($urandom), 1'($urandom));
      end else if (r < 70) begin
        if ($urandom_range(0, 1) != 0) a = (rt.addr & 32'hFFFF_F000) | (a & 32'h0000_0FFF);
        if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_ADD, rt.addr, rt.plen, $urandom, 16'($urandom), 1'($urandom));
        end else begin
          send_word(CMD_ADD, a, pick_len(), $urandom, 16'($urandom), 1'($urandom));
        end
      end else if (r < 90) begin
        if ($urandom_range(0, 4) == 0) rt.gw ^= 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 5) == 0) rt.port ^= 16'd1 << $urandom_range(0, 15);
        send_word(CMD_REMOVE, rt.addr | ($urandom & 32'h0000_00FF), rt.plen, rt.gw,
                  rt.port, 1'($urandom));
      end else if (r < 97) begin
        send_word(CMD_REMOVE, a, pick_len(), $urandom, 16'($urandom), 1'($urandom));
      end else begin
        send_word(CmdUnused, a, 6'($urandom), $urandom, 16'($urandom), 1'($urandom));
      end
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mbt_pkg.sv
src/mbt_front.sv
src/mbt_engine.sv
src/multibit_trie_route_lookup.sv
tb/route_table_checker.sv
tb/tb.sv
